>>> rtl/simplex_tableau_solver_macros.svh
// ----------------------------------------------------------------------------
// Simplex tableau solver assertion macros
// Shared property shapes, clocked on clk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef SIMPLEX_TABLEAU_SOLVER_MACROS_SVH
`define SIMPLEX_TABLEAU_SOLVER_MACROS_SVH

// same-cycle implication
`define STS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define STS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/stp_pkg.sv
// ----------------------------------------------------------------------------
// Simplex tableau solver package
// Tableau sizes, field widths, action and status codes, table addressing.
// ----------------------------------------------------------------------------
package stp_pkg;

  localparam int NUM_ROWS = 4;
  localparam int DIM_Y    = 8;
  localparam int NCOLS    = DIM_Y + 1;
  localparam int DEPTH    = (NUM_ROWS + 1) * NCOLS;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int TROW_W = $clog2(NUM_ROWS + 2);
  localparam int JW     = $clog2(NCOLS + 1);
  localparam int NBW    = (DIM_Y > 1) ? $clog2(DIM_Y) : 1;
  localparam int KMAX   = (NUM_ROWS > DIM_Y) ? NUM_ROWS : DIM_Y;
  localparam int KW     = $clog2(KMAX + 1);

  localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  localparam logic [2:0] ACT_COST     = 3'd0;
  localparam logic [2:0] ACT_CONS     = 3'd1;
  localparam logic [2:0] ACT_BASIC    = 3'd2;
  localparam logic [2:0] ACT_NONBASIC = 3'd3;
  localparam logic [2:0] ACT_SOLVE    = 3'd4;

  localparam logic [1:0] ST_OPTIMAL   = 2'd0;
  localparam logic [1:0] ST_UNBOUNDED = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;

  localparam logic CFG_ENTRY_LIMIT = 1'b0;
  localparam logic CFG_ITER_LIMIT  = 1'b1;

  typedef logic signed [31:0] q_t;

  // row NUM_ROWS holds the cost row
  function automatic logic [ADDR_W-1:0] tab_addr(input logic [TROW_W-1:0] r,
                                                 input logic [JW-1:0] c);
    tab_addr = ADDR_W'(int'(r) * NCOLS + int'(c));
  endfunction

endpackage

>>> rtl/simplex_tableau_solver.sv
// ----------------------------------------------------------------------------
// Simplex tableau solver
// Loads a tableau and basis lists, then solves by Dantzig pivoting in Q16.16.
// ----------------------------------------------------------------------------
// Load beats are taken one per cycle while the solver is idle. A solve beat
// holds the input stalled until all DIM_Y solution beats are handed to the
// output register. The tableau and cost row sit in one single-port-read
// synchronous table, so every element move is a read, compute and write in
// turn. Each quotient comes from a restoring divider at one bit per cycle; a
// pivot takes one quotient per row element normalized and a read, multiply
// and write per element eliminated in each other row, and a Dantzig step adds
// a cost scan over the DIM_Y nonbasic slots and a ratio test of up to
// NUM_ROWS quotients. The length of a solve is set by entry_limit and
// iteration_limit.
module simplex_tableau_solver (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [9:0]          cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_action,
  input  logic [4:0]          in_row,
  input  logic [6:0]          in_column,
  input  stp_pkg::q_t         in_value,
  input  logic [5:0]          in_list_slot,
  input  logic signed [6:0]   in_variable,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [5:0]          out_var_index,
  output stp_pkg::q_t         out_var_value,
  output logic [1:0]          out_status,
  output logic                out_last
);
  import stp_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_PRE      = 5'd1;
  localparam logic [4:0] S_STEP     = 5'd2;
  localparam logic [4:0] S_SCAN     = 5'd3;
  localparam logic [4:0] S_SCAN_CHK = 5'd4;
  localparam logic [4:0] S_RAT_RD   = 5'd5;
  localparam logic [4:0] S_RAT_A    = 5'd6;
  localparam logic [4:0] S_RAT_N    = 5'd7;
  localparam logic [4:0] S_RAT_CMP  = 5'd8;
  localparam logic [4:0] S_DIV      = 5'd9;
  localparam logic [4:0] S_PIV      = 5'd10;
  localparam logic [4:0] S_PIV_D    = 5'd11;
  localparam logic [4:0] S_NRM_RD   = 5'd12;
  localparam logic [4:0] S_NRM_DIV  = 5'd13;
  localparam logic [4:0] S_NRM_WR   = 5'd14;
  localparam logic [4:0] S_ELIM_T   = 5'd15;
  localparam logic [4:0] S_ELIM_M   = 5'd16;
  localparam logic [4:0] S_EL_RP    = 5'd17;
  localparam logic [4:0] S_EL_RT    = 5'd18;
  localparam logic [4:0] S_EL_MUL   = 5'd19;
  localparam logic [4:0] S_EL_WR    = 5'd20;
  localparam logic [4:0] S_PIV_DONE = 5'd21;
  localparam logic [4:0] S_OUT_RD   = 5'd22;
  localparam logic [4:0] S_OUT_LD   = 5'd23;

  // tableau memory
  q_t                mem [0:DEPTH-1];
  q_t                rd_data_r;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  q_t                wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  // basis lists
  logic signed [6:0] basic_r [NUM_ROWS];
  logic signed [6:0] nonbasic_r [DIM_Y];

  logic [4:0]         state_r, state_nxt, div_ret_r, div_ret_nxt;
  logic [6:0]         entry_limit_r, entry_limit_nxt;
  logic [9:0]         iter_limit_r, iter_limit_nxt, steps_r, steps_nxt;
  logic [KW-1:0]      k_r, k_nxt;
  logic [JW-1:0]      j_r, j_nxt, ec_r, ec_nxt, ev_r, ev_nxt;
  logic [TROW_W-1:0]  t_r, t_nxt;
  logic [ROW_W-1:0]   pr_r, pr_nxt, best_row_r, best_row_nxt, out_row;
  logic [NBW-1:0]     ei_r, ei_nxt;
  logic               presolve_r, presolve_nxt, have_r, have_nxt;
  logic               have_row_r, have_row_nxt, found_r, found_nxt;
  q_t                 best_r, best_nxt, best_ratio_r, best_ratio_nxt;
  q_t                 dsor_r, dsor_nxt, m_r, m_nxt, tv_r, tv_nxt, mres_r, mres_nxt;
  logic signed [63:0] prod_r, prod_nxt;
  logic [1:0]         status_r, status_nxt;
  logic [47:0]        num_r, num_nxt, quo_r, quo_nxt;
  logic [31:0]        den_r, den_nxt, rem_r, rem_nxt;
  logic [5:0]         dcnt_r, dcnt_nxt;
  logic               neg_r, neg_nxt, zero_r, zero_nxt, aneg_r, aneg_nxt;
  logic               out_valid_r, out_valid_nxt, out_load;
  logic [5:0]         out_index_r;
  q_t                 out_value_r;
  logic [1:0]         out_status_r;
  logic               out_last_r;
  logic               basic_we, nb_we, swap_we;

  // divider step and result
  logic [32:0]        rem_sh;
  logic               div_ge;
  q_t                 div_res;
  logic [31:0]        st_amag, st_bmag;

  always_comb begin
    rem_sh = {rem_r, num_r[47]};
    div_ge = rem_sh >= {1'b0, den_r};
    if (zero_r) begin
      div_res = aneg_r ? Q_MIN : Q_MAX;
    end else if (neg_r) begin
      div_res = (quo_r > 48'h0000_8000_0000) ? Q_MIN : q_t'(-quo_r[31:0]);
    end else begin
      div_res = (quo_r > 48'h0000_7FFF_FFFF) ? Q_MAX : q_t'(quo_r[31:0]);
    end
    st_amag = rd_data_r[31] ? 32'(-rd_data_r) : rd_data_r;
    st_bmag = dsor_r[31] ? 32'(-dsor_r) : dsor_r;
  end

  // product saturation and saturated difference
  logic signed [47:0] prod_sh;
  q_t                 mul_sat;
  logic signed [32:0] diff;
  q_t                 diff_sat;

  always_comb begin
    prod_sh = prod_r[63:16];
    if (prod_sh > 48'sh0000_7FFF_FFFF)       mul_sat = Q_MAX;
    else if (prod_sh < -48'sh0000_8000_0000) mul_sat = Q_MIN;
    else                                     mul_sat = q_t'(prod_sh[31:0]);
    diff = 33'(tv_r) - 33'(mres_r);
    if (diff[32] != diff[31]) diff_sat = diff[32] ? Q_MIN : Q_MAX;
    else                      diff_sat = q_t'(diff[31:0]);
  end

  // scan helpers
  logic signed [6:0] nb_v;
  logic              nb_ok;
  logic [7:0]        pre_col;
  logic              out_found;

  always_comb begin
    nb_v    = nonbasic_r[k_r[NBW-1:0]];
    nb_ok   = !nb_v[6] && (int'(nb_v) < DIM_Y) && (nb_v < entry_limit_r);
    pre_col = 8'(entry_limit_r) + 8'(k_r);
    // higher row wins
    out_found = 1'b0;
    out_row   = '0;
    for (int r = 0; r < NUM_ROWS; r++) begin
      if (basic_r[r] == 7'(k_r)) begin
        out_found = 1'b1;
        out_row   = ROW_W'(r);
      end
    end
  end

  always_comb begin
    state_nxt       = state_r;
    div_ret_nxt     = div_ret_r;
    entry_limit_nxt = entry_limit_r;
    iter_limit_nxt  = iter_limit_r;
    steps_nxt       = steps_r;
    k_nxt           = k_r;
    j_nxt           = j_r;
    t_nxt           = t_r;
    ec_nxt          = ec_r;
    ev_nxt          = ev_r;
    pr_nxt          = pr_r;
    best_row_nxt    = best_row_r;
    ei_nxt          = ei_r;
    presolve_nxt    = presolve_r;
    have_nxt        = have_r;
    have_row_nxt    = have_row_r;
    found_nxt       = found_r;
    best_nxt        = best_r;
    best_ratio_nxt  = best_ratio_r;
    dsor_nxt        = dsor_r;
    m_nxt           = m_r;
    tv_nxt          = tv_r;
    mres_nxt        = mres_r;
    prod_nxt        = prod_r;
    status_nxt      = status_r;
    num_nxt         = num_r;
    quo_nxt         = quo_r;
    den_nxt         = den_r;
    rem_nxt         = rem_r;
    dcnt_nxt        = dcnt_r;
    neg_nxt         = neg_r;
    zero_nxt        = zero_r;
    aneg_nxt        = aneg_r;
    rd_en           = 1'b0;
    rd_addr         = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = '0;
    basic_we        = 1'b0;
    nb_we           = 1'b0;
    swap_we         = 1'b0;
    out_load        = 1'b0;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENTRY_LIMIT: entry_limit_nxt = cfg_data[6:0];
        CFG_ITER_LIMIT:  iter_limit_nxt  = cfg_data;
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_action)
            ACT_COST: begin
              wr_en   = int'(in_column) < NCOLS;
              wr_addr = tab_addr(TROW_W'(NUM_ROWS), JW'(in_column));
              wr_data = in_value;
            end
            ACT_CONS: begin
              wr_en   = (int'(in_row) < NUM_ROWS) && (int'(in_column) < NCOLS);
              wr_addr = tab_addr(TROW_W'(in_row), JW'(in_column));
              wr_data = in_value;
            end
            ACT_BASIC:    basic_we = int'(in_row) < NUM_ROWS;
            ACT_NONBASIC: nb_we    = int'(in_list_slot) < DIM_Y;
            ACT_SOLVE: begin
              presolve_nxt = 1'b1;
              k_nxt        = '0;
              state_nxt    = S_PRE;
            end
            default: ;
          endcase
        end
      end
      S_PRE: begin
        if (k_r == KW'(NUM_ROWS)) begin
          presolve_nxt = 1'b0;
          steps_nxt    = '0;
          state_nxt    = S_STEP;
        end else if (int'(pre_col) < DIM_Y) begin
          pr_nxt    = k_r[ROW_W-1:0];
          ec_nxt    = JW'(pre_col);
          state_nxt = S_PIV;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_STEP: begin
        k_nxt = '0;
        if (steps_r == iter_limit_r) begin
          status_nxt = ST_LIMIT;
          state_nxt  = S_OUT_RD;
        end else begin
          have_nxt  = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (k_r == KW'(DIM_Y)) begin
          k_nxt = '0;
          if (!have_r) begin
            status_nxt = ST_OPTIMAL;
            state_nxt  = S_OUT_RD;
          end else begin
            have_row_nxt = 1'b0;
            state_nxt    = S_RAT_RD;
          end
        end else if (nb_ok) begin
          rd_en     = 1'b1;
          rd_addr   = tab_addr(TROW_W'(NUM_ROWS), JW'(nb_v));
          state_nxt = S_SCAN_CHK;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end
      S_SCAN_CHK: begin
        if (rd_data_r < 0 && (!have_r || rd_data_r < best_r)) begin
          have_nxt = 1'b1;
          best_nxt = rd_data_r;
          ev_nxt   = JW'(nb_v);
          ei_nxt   = k_r[NBW-1:0];
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = S_SCAN;
      end
      S_RAT_RD: begin
        if (k_r == KW'(NUM_ROWS)) begin
          if (!have_row_r) begin
            status_nxt = ST_UNBOUNDED;
            k_nxt      = '0;
            state_nxt  = S_OUT_RD;
          end else begin
            pr_nxt    = best_row_r;
            ec_nxt    = ev_r;
            state_nxt = S_PIV;
          end
        end else begin
          rd_en     = 1'b1;
          rd_addr   = tab_addr(TROW_W'(k_r), ev_r);
          state_nxt = S_RAT_A;
        end
      end
      S_RAT_A: begin
        if (rd_data_r > 0) begin
          dsor_nxt  = rd_data_r;
          rd_en     = 1'b1;
          rd_addr   = tab_addr(TROW_W'(k_r), JW'(DIM_Y));
          state_nxt = S_RAT_N;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_RAT_RD;
        end
      end
      S_RAT_N, S_NRM_DIV: begin
        // launch a divide of the read word by dsor_r
        aneg_nxt    = rd_data_r[31];
        neg_nxt     = rd_data_r[31] ^ dsor_r[31];
        zero_nxt    = dsor_r == 0;
        num_nxt     = {st_amag, 16'h0000};
        den_nxt     = st_bmag;
        rem_nxt     = '0;
        quo_nxt     = '0;
        dcnt_nxt    = '0;
        div_ret_nxt = (state_r == S_RAT_N) ? S_RAT_CMP : S_NRM_WR;
        state_nxt   = S_DIV;
      end
      S_RAT_CMP: begin
        if (!have_row_r || div_res < best_ratio_r) begin
          have_row_nxt   = 1'b1;
          best_ratio_nxt = div_res;
          best_row_nxt   = k_r[ROW_W-1:0];
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = S_RAT_RD;
      end
      S_DIV: begin
        rem_nxt  = div_ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
        quo_nxt  = {quo_r[46:0], div_ge};
        num_nxt  = {num_r[46:0], 1'b0};
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == 6'd47) state_nxt = div_ret_r;
      end
      S_PIV: begin
        rd_en     = 1'b1;
        rd_addr   = tab_addr(TROW_W'(pr_r), ec_r);
        state_nxt = S_PIV_D;
      end
      S_PIV_D: begin
        dsor_nxt = rd_data_r;
        if (rd_data_r == Q_ONE) begin
          t_nxt     = '0;
          state_nxt = S_ELIM_T;
        end else begin
          j_nxt     = '0;
          state_nxt = S_NRM_RD;
        end
      end
      S_NRM_RD: begin
        if (j_r == JW'(NCOLS)) begin
          wr_en     = 1'b1;
          wr_addr   = tab_addr(TROW_W'(pr_r), ec_r);
          wr_data   = Q_ONE;
          t_nxt     = '0;
          state_nxt = S_ELIM_T;
        end else if (j_r == ec_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = tab_addr(TROW_W'(pr_r), j_r);
          state_nxt = S_NRM_DIV;
        end
      end
      S_NRM_WR: begin
        wr_en     = 1'b1;
        wr_addr   = tab_addr(TROW_W'(pr_r), j_r);
        wr_data   = div_res;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_NRM_RD;
      end
      S_ELIM_T: begin
        if (t_r == TROW_W'(NUM_ROWS + 1)) begin
          state_nxt = S_PIV_DONE;
        end else if (t_r == TROW_W'(pr_r)) begin
          t_nxt = t_r + 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = tab_addr(t_r, ec_r);
          state_nxt = S_ELIM_M;
        end
      end
      S_ELIM_M: begin
        m_nxt = rd_data_r;
        if (rd_data_r == 0) begin
          t_nxt     = t_r + 1'b1;
          state_nxt = S_ELIM_T;
        end else begin
          j_nxt     = '0;
          state_nxt = S_EL_RP;
        end
      end
      S_EL_RP: begin
        if (j_r == JW'(NCOLS)) begin
          wr_en     = 1'b1;
          wr_addr   = tab_addr(t_r, ec_r);
          wr_data   = '0;
          t_nxt     = t_r + 1'b1;
          state_nxt = S_ELIM_T;
        end else if (j_r == ec_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = tab_addr(TROW_W'(pr_r), j_r);
          state_nxt = S_EL_RT;
        end
      end
      S_EL_RT: begin
        prod_nxt  = m_r * rd_data_r;
        rd_en     = 1'b1;
        rd_addr   = tab_addr(t_r, j_r);
        state_nxt = S_EL_MUL;
      end
      S_EL_MUL: begin
        tv_nxt    = rd_data_r;
        mres_nxt  = mul_sat;
        state_nxt = S_EL_WR;
      end
      S_EL_WR: begin
        wr_en     = 1'b1;
        wr_addr   = tab_addr(t_r, j_r);
        wr_data   = diff_sat;
        j_nxt     = j_r + 1'b1;
        state_nxt = S_EL_RP;
      end
      S_PIV_DONE: begin
        if (presolve_r) begin
          k_nxt     = k_r + 1'b1;
          state_nxt = S_PRE;
        end else begin
          swap_we   = 1'b1;
          steps_nxt = steps_r + 1'b1;
          state_nxt = S_STEP;
        end
      end
      S_OUT_RD: begin
        found_nxt = out_found;
        if (out_found) begin
          rd_en   = 1'b1;
          rd_addr = tab_addr(TROW_W'(out_row), JW'(DIM_Y));
        end
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        // hold until the output register frees up
        if (!out_valid_r || !out_stall) begin
          out_load = 1'b1;
          if (k_r == KW'(DIM_Y - 1)) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_load | (out_valid_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      entry_limit_r <= 7'd1;
      iter_limit_r  <= 10'd32;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      entry_limit_r <= entry_limit_nxt;
      iter_limit_r  <= iter_limit_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_ret_r    <= div_ret_nxt;
    steps_r      <= steps_nxt;
    k_r          <= k_nxt;
    j_r          <= j_nxt;
    t_r          <= t_nxt;
    ec_r         <= ec_nxt;
    ev_r         <= ev_nxt;
    pr_r         <= pr_nxt;
    best_row_r   <= best_row_nxt;
    ei_r         <= ei_nxt;
    presolve_r   <= presolve_nxt;
    have_r       <= have_nxt;
    have_row_r   <= have_row_nxt;
    found_r      <= found_nxt;
    best_r       <= best_nxt;
    best_ratio_r <= best_ratio_nxt;
    dsor_r       <= dsor_nxt;
    m_r          <= m_nxt;
    tv_r         <= tv_nxt;
    mres_r       <= mres_nxt;
    prod_r       <= prod_nxt;
    status_r     <= status_nxt;
    num_r        <= num_nxt;
    quo_r        <= quo_nxt;
    den_r        <= den_nxt;
    rem_r        <= rem_nxt;
    dcnt_r       <= dcnt_nxt;
    neg_r        <= neg_nxt;
    zero_r       <= zero_nxt;
    aneg_r       <= aneg_nxt;
    if (basic_we) basic_r[in_row[ROW_W-1:0]] <= in_variable;
    if (nb_we) nonbasic_r[in_list_slot[NBW-1:0]] <= in_variable;
    if (swap_we) begin
      basic_r[pr_r]    <= nonbasic_r[ei_r];
      nonbasic_r[ei_r] <= basic_r[pr_r];
    end
    if (out_load) begin
      out_index_r  <= 6'(k_r);
      out_value_r  <= found_r ? rd_data_r : '0;
      out_last_r   <= k_r == KW'(DIM_Y - 1);
      out_status_r <= (k_r == KW'(DIM_Y - 1)) ? status_r : ST_OPTIMAL;
    end
  end

  assign in_stall      = state_r != S_IDLE;
  assign out_valid     = out_valid_r;
  assign out_var_index = out_index_r;
  assign out_var_value = out_value_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

endmodule

>>> rtl/stp_checker.sv
// ----------------------------------------------------------------------------
// Simplex tableau solver port checker
// Watches the result channel of the top level; bound in below.
// ----------------------------------------------------------------------------
`include "simplex_tableau_solver_macros.svh"

module stp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input logic [5:0]        out_var_index,
  input stp_pkg::q_t       out_var_value,
  input logic [1:0]        out_status,
  input logic              out_last
);
  import stp_pkg::*;

  `STS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_var_value) && $stable(out_var_index), "stalled result beat changed")
  `STS_ASSERT_NOW(a_status_last, out_valid && !out_last, out_status == ST_OPTIMAL, "status on a non-final beat")
  `STS_ASSERT_NOW(a_last_index, out_valid && out_last, out_var_index == 6'(DIM_Y - 1), "final beat not on last variable")
  `STS_ASSERT_NOW(a_status_code, out_valid && out_last, out_status == ST_OPTIMAL || out_status == ST_UNBOUNDED || out_status == ST_LIMIT, "bad status code")

endmodule

bind simplex_tableau_solver stp_checker u_stp_checker (.*);
